>>> src/nbu_pkg.sv
`timescale 1ns / 1ps

package nbu_pkg;

  localparam int unsigned INDEX_W = 9;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CODE_W  = 2;

  localparam int unsigned BLK_LEN_S = 128;
  localparam int unsigned BLK_LEN_M = 256;
  localparam int unsigned BLK_LEN_L = 512;

  localparam int unsigned DEFAULT_MAX_BLOCK = 512;

  // Read selection works in groups of this many cells.
  localparam int unsigned LANES  = 32;
  localparam int unsigned LANE_W = 5;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [CODE_W-1:0] BLK_CODE_S = 2'd0;
  localparam logic [CODE_W-1:0] BLK_CODE_M = 2'd1;
  localparam logic [CODE_W-1:0] BLK_CODE_L = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_BLOCK_SIZE = 1'b0,
    REG_UNBIND     = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_RESP
  } state_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                     shift;
    logic                     acc;
    logic                     use_next;
    logic                     clr;
    logic                     wr;
    logic [INDEX_W-1:0]       wr_addr;
    logic                     wr_bit;
    logic [INDEX_W-1:0]       j;
    logic signed [COEF_W-1:0] coef;
  } cell_ctrl_t;

  // Block length for a size code, capped at the number of cells built.
  function automatic logic [LEN_W-1:0] blk_len(logic [CODE_W-1:0] code, int unsigned ncell);
    int unsigned n;
    case (code)
      BLK_CODE_S: n = BLK_LEN_S;
      BLK_CODE_M: n = BLK_LEN_M;
      default:    n = BLK_LEN_L;
    endcase
    if (n > ncell) n = ncell;
    return LEN_W'(n);
  endfunction

endpackage

>>> src/nbu_if.sv
`timescale 1ns / 1ps

interface nbu_in_if import nbu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [INDEX_W-1:0]       index;
  logic                     sign_bit;
  logic signed [COEF_W-1:0] coefficient;

  modport source (output valid, command, index, sign_bit, coefficient, input ready);
  modport sink (input valid, command, index, sign_bit, coefficient, output ready);
endinterface

interface nbu_out_if import nbu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] result_value;
  logic [INDEX_W-1:0]      result_index;
  logic                    range_error;

  modport source (output valid, result_value, result_index, range_error, input ready);
  modport sink (input valid, result_value, result_index, range_error, output ready);
endinterface

>>> src/negacyclic_bind_unbind.sv
`timescale 1ns / 1ps

// Negacyclic bind/unbind engine: a row of cells, one per element, each holding
// a stored sign and a 48-bit saturating accumulator. The sign vector lives in
// a ring that rotates one cell per clock while it steps; an accumulate word
// with index j adds +/-coefficient into every active accumulator in parallel
// once the ring rotation equals j. Load and clear finish in the execute state,
// as does an accumulate whose j equals the current rotation or the one after
// it, so a coefficient stream with consecutive rising indices runs at one word
// per clock; otherwise the ring steps one cell at a time until the rotation
// reaches j. A read passes through the execute, read and response states, an
// out-of-range word through execute and response, and both wait in response
// while the output register holds an untaken word; the read's extra state covers
// the two-stage registered read select. After the block size changes, the first
// load or accumulate turns the ring back to rotation zero, then switches length.

module negacyclic_bind_unbind import nbu_pkg::*; #(
  parameter int unsigned MAX_BLOCK = DEFAULT_MAX_BLOCK
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nbu_in_if.sink            in_i,
  nbu_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned NCELL = (MAX_BLOCK < BLK_LEN_L) ? MAX_BLOCK : BLK_LEN_L;
  localparam int unsigned LEN0  = blk_len(BLK_CODE_S, NCELL);
  localparam int unsigned LEN1  = blk_len(BLK_CODE_M, NCELL);
  localparam int unsigned LEN2  = blk_len(BLK_CODE_L, NCELL);

  logic [CODE_W-1:0]       code_q;
  logic                    unbind_q;
  logic [CODE_W-1:0]       ring_code;
  logic [INDEX_W-1:0]      rd_index;
  logic signed [ACC_W-1:0] rd_value;
  cell_ctrl_t              cell_ctrl;

  logic                    cell_sign [NCELL];
  logic signed [ACC_W-1:0] cell_acc  [NCELL];
  logic                    wrap_sign;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q   <= BLK_CODE_L;
      unbind_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[2]))
        REG_BLOCK_SIZE: code_q   <= pwdata[CODE_W-1:0];
        REG_UNBIND:     unbind_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_BLOCK_SIZE: prdata = APB_DW'(code_q);
      REG_UNBIND:     prdata = APB_DW'(unbind_q);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  nbu_ctrl #(
    .NCELL(NCELL)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .command_i      (in_i.command),
    .index_i        (in_i.index),
    .sign_bit_i     (in_i.sign_bit),
    .coefficient_i  (in_i.coefficient),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_value_o (out_o.result_value),
    .result_index_o (out_o.result_index),
    .range_error_o  (out_o.range_error),
    .cfg_code_i     (code_q),
    .unbind_i       (unbind_q),
    .rd_value_i     (rd_value),
    .rd_index_o     (rd_index),
    .ring_code_o    (ring_code),
    .cell_ctrl_o    (cell_ctrl)
  );

  // The last cell of the current block length feeds cell zero.
  always_comb begin
    case (ring_code)
      BLK_CODE_S: wrap_sign = cell_sign[LEN0-1];
      BLK_CODE_M: wrap_sign = cell_sign[LEN1-1];
      default:    wrap_sign = cell_sign[LEN2-1];
    endcase
  end

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    logic active;
    logic sign_in;

    if (c < LEN0) begin : g_act_s
      assign active = 1'b1;
    end else if (c < LEN1) begin : g_act_m
      assign active = (ring_code != BLK_CODE_S);
    end else begin : g_act_l
      assign active = (ring_code != BLK_CODE_S) && (ring_code != BLK_CODE_M);
    end

    if (c == 0) begin : g_head
      assign sign_in = wrap_sign;
    end else begin : g_body
      assign sign_in = cell_sign[c-1];
    end

    nbu_cell #(
      .IDX(c)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .active_i  (active),
      .sign_in_i (sign_in),
      .sign_o    (cell_sign[c]),
      .acc_o     (cell_acc[c])
    );
  end

  nbu_rdsel #(
    .NCELL(NCELL)
  ) u_rdsel (
    .clk_i   (clk_i),
    .acc_i   (cell_acc),
    .index_i (rd_index),
    .value_o (rd_value)
  );

endmodule

>>> src/nbu_cell.sv
`timescale 1ns / 1ps

module nbu_cell import nbu_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic                    active_i,
  input  logic                    sign_in_i,
  output logic                    sign_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic                    sign_q, sign_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    sel_sign;
  logic                    before_j;
  logic                    neg;
  logic signed [COEF_W:0]  coef_x;
  logic signed [COEF_W:0]  delta;
  logic signed [ACC_W:0]   sum;

  assign before_j = INDEX_W'(IDX) < ctrl_i.j;
  // When the ring steps and accumulates in the same cycle, the sign arriving
  // from the neighbor is the one that lines up with the coefficient.
  assign sel_sign = ctrl_i.use_next ? sign_in_i : sign_q;
  // A stored zero means -1; positions that wrapped around flip once more.
  assign neg      = ~sel_sign ^ before_j;
  assign coef_x   = (COEF_W+1)'(ctrl_i.coef);
  assign delta    = neg ? -coef_x : coef_x;
  assign sum      = (ACC_W+1)'(acc_q) + (ACC_W+1)'(delta);

  always_comb begin
    sign_d = sign_q;
    if (active_i && ctrl_i.shift) begin
      sign_d = sign_in_i;
    end else if (ctrl_i.wr && (ctrl_i.wr_addr == INDEX_W'(IDX))) begin
      sign_d = ctrl_i.wr_bit;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (active_i && ctrl_i.acc) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_d = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_d = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign sign_o = sign_q;
  assign acc_o  = acc_q;

endmodule

>>> src/nbu_rdsel.sv
`timescale 1ns / 1ps

module nbu_rdsel import nbu_pkg::*; #(
  parameter int unsigned NCELL = DEFAULT_MAX_BLOCK
) (
  input  logic                    clk_i,
  input  logic signed [ACC_W-1:0] acc_i [NCELL],
  input  logic [INDEX_W-1:0]      index_i,
  output logic signed [ACC_W-1:0] value_o
);

  localparam int unsigned NGRP  = (NCELL + LANES - 1) / LANES;
  localparam int unsigned GRP_W = $clog2(NGRP);

  logic signed [ACC_W-1:0] grp_q [NGRP];
  logic signed [ACC_W-1:0] value_q;
  logic [LANE_W-1:0]       lane_sel;
  logic [GRP_W-1:0]        grp_sel;

  assign lane_sel = index_i[LANE_W-1:0];
  assign grp_sel  = index_i[LANE_W +: GRP_W];

  // First stage picks the lane inside every group, second stage the group.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic signed [ACC_W-1:0] lane [LANES];
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (g * LANES + l < NCELL) begin : g_used
        assign lane[l] = acc_i[g*LANES+l];
      end else begin : g_pad
        assign lane[l] = '0;
      end
    end
    always_ff @(posedge clk_i) begin
      grp_q[g] <= lane[lane_sel];
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= grp_q[grp_sel];
  end

  assign value_o = value_q;

endmodule

>>> src/nbu_ctrl.sv
`timescale 1ns / 1ps

module nbu_ctrl import nbu_pkg::*; #(
  parameter int unsigned NCELL = DEFAULT_MAX_BLOCK
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [INDEX_W-1:0]       index_i,
  input  logic                     sign_bit_i,
  input  logic signed [COEF_W-1:0] coefficient_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ACC_W-1:0]  result_value_o,
  output logic [INDEX_W-1:0]       result_index_o,
  output logic                     range_error_o,
  input  logic [CODE_W-1:0]        cfg_code_i,
  input  logic                     unbind_i,
  input  logic signed [ACC_W-1:0]  rd_value_i,
  output logic [INDEX_W-1:0]       rd_index_o,
  output logic [CODE_W-1:0]        ring_code_o,
  output cell_ctrl_t               cell_ctrl_o
);

  state_e                   state_q, state_d;
  logic [INDEX_W-1:0]       rot_q, rot_d;
  logic [CODE_W-1:0]        ring_code_q, ring_code_d;

  cmd_e                     cmd_q;
  logic [INDEX_W-1:0]       idx_q;
  logic                     sbit_q;
  logic signed [COEF_W-1:0] coef_q;

  logic                     ov_q;
  logic signed [ACC_W-1:0]  val_q;
  logic [INDEX_W-1:0]       oidx_q;
  logic                     oerr_q;

  logic [LEN_W-1:0]         n_ring, n_cfg;
  logic [LEN_W-1:0]         idx_x, rot_x, rot_nx;
  logic [INDEX_W-1:0]       rot_inc;
  logic                     range_err, realign, involute;
  logic [LEN_W-1:0]         pos, addr_sum, addr_wrap;
  logic                     done, load_out;
  cell_ctrl_t               cc;

  assign n_ring    = blk_len(ring_code_q, NCELL);
  assign n_cfg     = blk_len(cfg_code_i, NCELL);
  assign idx_x     = LEN_W'(idx_q);
  assign rot_x     = LEN_W'(rot_q);
  assign rot_nx    = rot_x + LEN_W'(1);
  assign rot_inc   = (rot_nx == n_ring) ? '0 : rot_nx[INDEX_W-1:0];
  assign range_err = idx_x >= n_cfg;
  // The ring only takes a new length while it sits unrotated.
  assign realign   = n_ring != n_cfg;

  // Logical sign position p lives in cell (p + rotation) mod N.
  assign involute  = unbind_i && (idx_q != '0);
  assign pos       = involute ? (n_ring - idx_x) : idx_x;
  assign addr_sum  = pos + rot_x;
  assign addr_wrap = (addr_sum >= n_ring) ? (addr_sum - n_ring) : addr_sum;

  always_comb begin
    state_d        = state_q;
    rot_d          = rot_q;
    ring_code_d    = ring_code_q;
    done           = 1'b0;
    load_out       = 1'b0;
    cc             = '0;
    cc.j           = idx_q;
    cc.coef        = coef_q;
    cc.wr_addr     = addr_wrap[INDEX_W-1:0];
    cc.wr_bit      = involute ? ~sbit_q : sbit_q;
    case (state_q)
      ST_IDLE: begin
        done = 1'b1;
      end
      ST_EXEC: begin
        if (cmd_q == CMD_CLEAR) begin
          cc.clr = 1'b1;
          done   = 1'b1;
        end else if (range_err) begin
          state_d = ST_RESP;
        end else if (cmd_q == CMD_READ) begin
          state_d = ST_RD;
        end else if (realign) begin
          if (rot_q == '0) begin
            ring_code_d = cfg_code_i;
          end else begin
            cc.shift = 1'b1;
            rot_d    = rot_inc;
          end
        end else if (cmd_q == CMD_LOAD) begin
          cc.wr = 1'b1;
          done  = 1'b1;
        end else if (rot_q == idx_q) begin
          cc.acc = 1'b1;
          done   = 1'b1;
        end else begin
          cc.shift = 1'b1;
          rot_d    = rot_inc;
          if (rot_inc == idx_q) begin
            cc.acc      = 1'b1;
            cc.use_next = 1'b1;
            done        = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!ov_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (done) begin
      state_d = in_valid_i ? ST_EXEC : ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rot_q       <= '0;
      ring_code_q <= BLK_CODE_L;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      rot_q       <= rot_d;
      ring_code_q <= ring_code_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done && in_valid_i) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= index_i;
      sbit_q <= sign_bit_i;
      coef_q <= coefficient_i;
    end
    if (load_out) begin
      val_q  <= range_err ? '0 : rd_value_i;
      oidx_q <= idx_q;
      oerr_q <= range_err;
    end
  end

  assign in_ready_o     = done;
  assign out_valid_o    = ov_q;
  assign result_value_o = val_q;
  assign result_index_o = oidx_q;
  assign range_error_o  = oerr_q;
  assign rd_index_o     = idx_q;
  assign ring_code_o    = ring_code_q;
  assign cell_ctrl_o    = cc;

endmodule

>>> src/nbu_chk.sv
`timescale 1ns / 1ps

module nbu_chk import nbu_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [CMD_W-1:0]        command,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ACC_W-1:0] result_value,
  input logic [INDEX_W-1:0]      result_index,
  input logic                    range_error
);

  // A flagged word never carries an accumulator value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && range_error |-> result_value == '0)
    else $error("range error word with nonzero value");

  // A read is never finished in the cycle after it is taken.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (command == CMD_READ) |=> !in_ready)
    else $error("input taken while a read is in progress");

  // No word appears in the cycle right after an input is accepted.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("output word appeared too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(result_index) && $stable(range_error))
    else $error("stalled output word changed");

endmodule

bind negacyclic_bind_unbind nbu_chk u_nbu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .command      (in_i.command),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .result_value (out_o.result_value),
  .result_index (out_o.result_index),
  .range_error  (out_o.range_error)
);

>>> test/negacyclic_bind_unbind_test.sv
`timescale 1ns / 1ps

module negacyclic_bind_unbind_test;
  import nbu_pkg::*;

  localparam int unsigned N_CELLS       = DEFAULT_MAX_BLOCK;
  // Longest quiet spell of the block: ring return after a size change plus a full ring walk.
  localparam int unsigned SETTLE_CYCLES = 1100;
  localparam int unsigned STALL_LIMIT   = 8000;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam int unsigned SAT_STEPS     = 64;

  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct packed {
    cmd_e                     cmd;
    logic [INDEX_W-1:0]       idx;
    logic                     sbit;
    logic signed [COEF_W-1:0] coef;
  } word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [INDEX_W-1:0]      idx;
    logic                    range_err;
  } sum_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nbu_in_if  word_if ();
  nbu_out_if sum_if ();

  negacyclic_bind_unbind i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (word_if),
    .out_o   (sum_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the block: stored signs (1 = +1), running sums and registers.
  logic [N_CELLS-1:0] sign_ring = '0;
  longint             acc_sums [N_CELLS];
  logic [CODE_W-1:0]  size_code = BLK_CODE_L;
  logic               unbind_on = 1'b0;
  sum_t               sums_due [$];

  // Stimulus side: words waiting to go out and which sign positions hold a value.
  word_t              words_to_send [$];
  logic [N_CELLS-1:0] sign_known = '0;

  bit          word_live = 1'b0;
  bit          word_taken = 1'b0;
  int unsigned word_gap = 0;
  int unsigned word_quiet = 0;
  int unsigned sum_hold = 0;
  int unsigned sum_quiet = 0;
  int unsigned quiet_cycles = 0;

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned acc_words = 0;
  int unsigned sums_checked = 0;
  int unsigned range_hits = 0;
  int unsigned sat_hits = 0;
  int unsigned reg_writes = 0;

  function automatic int unsigned row_len(logic [CODE_W-1:0] code);
    int unsigned n;
    case (code)
      BLK_CODE_S: n = BLK_LEN_S;
      BLK_CODE_M: n = BLK_LEN_M;
      default:    n = BLK_LEN_L;
    endcase
    if (n > N_CELLS) n = N_CELLS;
    return n;
  endfunction

  function automatic longint clamp_sum(longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  // Random wait, with occasional runs of back-to-back transfers.
  function automatic int unsigned draw_wait(inout int unsigned quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet_left = $urandom_range(16, 64);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'h0000_0001;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic negacyclic_step(input word_t w);
    int unsigned n;
    int unsigned pos;
    logic        flip;
    longint      c;
    sum_t        due;
    n = row_len(size_code);
    c = longint'($signed(w.coef));
    if (w.cmd == CMD_CLEAR) begin
      foreach (acc_sums[i]) acc_sums[i] = 0;
    end else if (w.idx >= n) begin
      due.value = '0;
      due.idx = w.idx;
      due.range_err = 1'b1;
      sums_due.push_back(due);
    end else if (w.cmd == CMD_LOAD) begin
      if (unbind_on && w.idx != 0) sign_ring[n - w.idx] = ~w.sbit;
      else sign_ring[w.idx] = w.sbit;
    end else if (w.cmd == CMD_ACC) begin
      for (int unsigned k = 0; k < n; k++) begin
        pos = (k >= w.idx) ? k - w.idx : k + n - w.idx;
        // A -1 sign negates, and so does the wrap past the end of the row.
        flip = ~sign_ring[pos] ^ (k < w.idx);
        acc_sums[k] = clamp_sum(flip ? acc_sums[k] - c : acc_sums[k] + c);
      end
    end else begin
      due.value = ACC_W'(acc_sums[w.idx]);
      due.idx = w.idx;
      due.range_err = 1'b0;
      sums_due.push_back(due);
    end
  endtask

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic send_word(input cmd_e cmd, input int unsigned idx, input logic sbit,
                           input logic [COEF_W-1:0] coef);
    word_t       w;
    int unsigned n;
    n = row_len(size_code);
    w.cmd = cmd;
    w.idx = INDEX_W'(idx);
    w.sbit = sbit;
    w.coef = coef;
    words_to_send.push_back(w);
    if (cmd == CMD_LOAD && idx < n)
      sign_known[(unbind_on && idx != 0) ? n - idx : idx] = 1'b1;
    if (cmd == CMD_ACC) acc_words++;
  endtask

  // Waits until every word is out and every sum is back, then lets the ring settle.
  task automatic drain();
    while (words_to_send.size() != 0 || word_live || sums_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e which, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == REG_BLOCK_SIZE) size_code = value[CODE_W-1:0];
    else unbind_on = value[0];
    reg_writes++;
  endtask

  // Loads any sign position still unknown, then mixes coefficient streams with
  // rising indices, reads, sign reloads, clears and stray words.
  task automatic random_phase(input int unsigned budget);
    int unsigned n;
    int unsigned idx;
    int unsigned len;
    int unsigned count;
    n = row_len(size_code);
    for (int unsigned p = 0; p < n; p++) begin
      if (!sign_known[p])
        send_word(CMD_LOAD, (unbind_on && p != 0) ? n - p : p, $urandom_range(0, 1), $urandom);
    end
    count = 0;
    while (count < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          idx = $urandom_range(0, n - 1);
          len = $urandom_range(4, 24);
          for (int unsigned s = 0; s < len && idx < n; s++) begin
            send_word(CMD_ACC, idx, $urandom_range(0, 1), pick_coef());
            idx += ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
            count++;
          end
          repeat ($urandom_range(1, 4)) begin
            send_word(CMD_READ, $urandom_range(0, n - 1), $urandom_range(0, 1), $urandom);
            count++;
          end
        end
        6: begin
          repeat ($urandom_range(1, 6)) begin
            send_word(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 511),
                      $urandom_range(0, 1), $urandom);
            count++;
          end
        end
        7: begin
          repeat ($urandom_range(1, 8)) begin
            send_word(CMD_LOAD, $urandom_range(0, n - 1), $urandom_range(0, 1), $urandom);
            count++;
          end
        end
        8: begin
          send_word(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 1), $urandom);
          count++;
        end
        default: begin
          idx = (n < N_CELLS) ? $urandom_range(n, 511) : $urandom_range(0, 511);
          send_word(cmd_e'($urandom_range(0, 2)), idx, $urandom_range(0, 1), $urandom);
          count++;
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [CODE_W-1:0] code, input logic unbind,
                           input int unsigned budget);
    drain();
    write_reg(REG_BLOCK_SIZE, code);
    write_reg(REG_UNBIND, unbind);
    random_phase(budget);
  endtask

  always @(negedge clk_i) begin : word_driver
    word_t w;
    if (word_taken) begin
      word_taken = 1'b0;
      word_live = 1'b0;
      word_gap = draw_wait(word_quiet);
    end
    if (rst_ni && !word_live) begin
      if (word_gap > 0) begin
        word_gap--;
      end else if (words_to_send.size() > 0) begin
        w = words_to_send.pop_front();
        word_if.command <= w.cmd;
        word_if.index <= w.idx;
        word_if.sign_bit <= w.sbit;
        word_if.coefficient <= w.coef;
        word_live = 1'b1;
      end
    end
    word_if.valid <= word_live;
  end

  always @(negedge clk_i) begin : sum_ready_driver
    if (sum_hold > 0) begin
      sum_hold--;
      sum_if.ready <= 1'b0;
    end else begin
      sum_if.ready <= rst_ni;
    end
  end

  always @(posedge clk_i) begin : sum_monitor
    sum_t  got;
    sum_t  want;
    word_t w;
    bit    moved;
    if (rst_ni) begin
      moved = 1'b0;
      // Results first: a word taken on this edge cannot own the result seen on it.
      if (sum_if.valid && sum_if.ready) begin
        moved = 1'b1;
        got.value = sum_if.result_value;
        got.idx = sum_if.result_index;
        got.range_err = sum_if.range_error;
        if (got.range_err) range_hits++;
        else if (got.value == ACC_MAX || got.value == ACC_MIN) sat_hits++;
        if (sums_due.size() == 0) begin
          flag_mismatch("unrequested result at index", got.idx, -1);
        end else begin
          want = sums_due.pop_front();
          sums_checked++;
          if (got.value !== want.value)
            flag_mismatch("result_value", $signed(got.value), $signed(want.value));
          if (got.idx !== want.idx)
            flag_mismatch("result_index", got.idx, want.idx);
          if (got.range_err !== want.range_err)
            flag_mismatch("range_error", got.range_err, want.range_err);
        end
        sum_hold = draw_wait(sum_quiet);
      end
      if (word_if.valid && word_if.ready) begin
        moved = 1'b1;
        w.cmd = cmd_e'(word_if.command);
        w.idx = word_if.index;
        w.sbit = word_if.sign_bit;
        w.coef = word_if.coefficient;
        negacyclic_step(w);
        words_sent++;
        word_taken = 1'b1;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                   quiet_cycles, sums_due.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    word_if.valid = 1'b0;
    word_if.command = CMD_LOAD;
    word_if.index = '0;
    word_if.sign_bit = 1'b0;
    word_if.coefficient = '0;
    sum_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    foreach (acc_sums[i]) acc_sums[i] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the row is 512 long, so the top index reads a zero sum.
    send_word(CMD_READ, 0, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 511, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 0, 1'b0, 32'h0000_0000);
    drain();
    write_reg(REG_BLOCK_SIZE, BLK_CODE_S);
    write_reg(REG_UNBIND, 1'b0);
    // Any load, accumulate or read just past the end or at the top is rejected and flagged.
    send_word(CMD_LOAD, 128, 1'b1, 32'h0000_0000);
    send_word(CMD_LOAD, 511, 1'b0, 32'h7FFF_FFFF);
    send_word(CMD_ACC, 128, 1'b1, 32'h8000_0000);
    send_word(CMD_ACC, 511, 1'b0, 32'h7FFF_FFFF);
    send_word(CMD_READ, 128, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 511, 1'b1, 32'h8000_0000);
    send_word(CMD_READ, 127, 1'b0, 32'h0000_0000);
    send_word(CMD_LOAD, 0, 1'b0, 32'hFFFF_FFFF);
    send_word(CMD_LOAD, 127, 1'b1, 32'h0000_0001);
    send_word(CMD_CLEAR, 511, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_READ, 0, 1'b0, 32'h0000_0000);

    run_phase(BLK_CODE_S, 1'b0, 30);
    run_phase(BLK_CODE_S, 1'b1, 30);
    run_phase(BLK_CODE_M, 1'b1, 30);
    // The unused size code must behave as the longest row.
    run_phase(2'd3, 1'b0, 20);
    run_phase(BLK_CODE_M, 1'b0, 20);

    // Build large sums of both signs: a mixed sign pattern and the most negative
    // coefficient at index 0 push the +1 cells down and the -1 cells up.
    drain();
    write_reg(REG_BLOCK_SIZE, BLK_CODE_S);
    write_reg(REG_UNBIND, 1'b0);
    send_word(CMD_CLEAR, 0, 1'b0, 32'h0000_0000);
    send_word(CMD_LOAD, 0, 1'b1, $urandom);
    send_word(CMD_LOAD, 1, 1'b0, $urandom);
    for (int unsigned s = 0; s < SAT_STEPS; s++) begin
      send_word(CMD_ACC, 0, $urandom_range(0, 1), 32'h8000_0000);
      if (s % 16 == 0)
        send_word(CMD_READ, $urandom_range(0, BLK_LEN_S - 1), $urandom_range(0, 1), $urandom);
    end
    send_word(CMD_READ, 0, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 1, 1'b0, 32'h0000_0000);
    send_word(CMD_ACC, 0, 1'b1, 32'h7FFF_FFFF);
    repeat (6)
      send_word(CMD_READ, $urandom_range(0, BLK_LEN_S - 1), $urandom_range(0, 1), $urandom);
    send_word(CMD_CLEAR, 0, 1'b0, 32'h0000_0000);
    send_word(CMD_READ, 0, 1'b0, 32'h0000_0000);

    drain();
    $display("Ran %0d words (%0d accumulates) across %0d register writes;", words_sent,
             acc_words, reg_writes);
    $display("checked %0d results, %0d range errors, %0d sums at a 48-bit limit.",
             sums_checked, range_hits, sat_hits);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
src/nbu_pkg.sv
src/nbu_if.sv
src/nbu_cell.sv
src/nbu_rdsel.sv
src/nbu_ctrl.sv
src/negacyclic_bind_unbind.sv
src/nbu_chk.sv
test/negacyclic_bind_unbind_test.sv
